[src/rwa_pkg.sv]
`timescale 1ns / 1ps
// Rolling window average: shared constants, command codes and the
// control/status structs between controller and datapath. No dependencies.
package rwa_pkg;

  localparam int WINDOW_DEF = 64;
  localparam int CMD_W      = 1;
  localparam int DATA_W     = 32;
  localparam int FILL_W     = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } rwa_op_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic div_step;
    logic out_load;
  } rwa_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } rwa_stat_t;

endpackage

[src/rwa_if.sv]
`timescale 1ns / 1ps
// Rolling window average: valid/ready channel interfaces for sample beats
// and result beats. Depends on rwa_pkg.
interface rwa_in_if;
  import rwa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface rwa_out_if;
  import rwa_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] mean_value;
  logic              not_empty;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, output mean_value, output not_empty, output fill_count,
                  input ready);
  modport sink   (input valid, input mean_value, input not_empty, input fill_count,
                  output ready);
endinterface

[src/rolling_window_average_top.sv]
`timescale 1ns / 1ps
// Rolling window average top level: controller plus datapath, with the
// channel interfaces. Depends on rwa_pkg, rwa_if, rwa_ctrl, rwa_datapath.
//
//   channel  direction  handshake        payload
//   in_ch    sink       valid/ready      cmd[0:0], value[31:0]
//   out_ch   source     valid/ready      mean_value[31:0], not_empty, fill_count[6:0]
//
// A beat is handled in order: one ring read, one update, one divider load,
// one quotient bit per cycle from the restoring divider (SUM_W quotient bits,
// with SUM_W = 32 + clog2(WINDOW)), then one result load.
// Reset (rst_n low, synchronous) empties the window; the ring needs no clearing.
// A finished result waits in the output register while the next beat is taken;
// a stalled result holds the block only at the end of the following beat.
module rolling_window_average_top #(
  parameter int WINDOW = rwa_pkg::WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rwa_in_if.sink    in_ch,
  rwa_out_if.source out_ch
);
  import rwa_pkg::*;

  rwa_cmd_t  ctl;
  rwa_stat_t dp_st;
  logic      in_ready;

  rwa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .st      (dp_st),
    .cmd     (ctl)
  );

  rwa_datapath #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (ctl),
    .st            (dp_st),
    .in_cmd        (in_ch.cmd),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_mean_value(out_ch.mean_value),
    .out_not_empty (out_ch.not_empty),
    .out_fill_count(out_ch.fill_count)
  );

  assign in_ch.ready = in_ready;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a beat is in flight");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> dp_st.out_free)
    else $error("result loaded over an untaken result");

  a_empty_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.not_empty |-> out_ch.mean_value == '0)
    else $error("empty window with nonzero mean");

  a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |=> !dp_st.div_last)
    else $error("divider finished on its first step");

endmodule

[src/rwa_ram.sv]
`timescale 1ns / 1ps
// Rolling window average: generic single-write, single-read RAM with
// registered read data. No dependencies.
module rwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/rwa_ctrl.sv]
`timescale 1ns / 1ps
// Rolling window average: controller state machine. Sequences read,
// update, divide and result load. Depends on rwa_pkg.
module rwa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rwa_pkg::rwa_stat_t st,
  output rwa_pkg::rwa_cmd_t  cmd
);
  import rwa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.update = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[src/rwa_datapath.sv]
`timescale 1ns / 1ps
// Rolling window average: sample ring, running sum, fill count, cursor,
// restoring divider and result register. Depends on rwa_pkg and rwa_ram.
module rwa_datapath #(
  parameter int WINDOW = rwa_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rwa_pkg::rwa_cmd_t          cmd,
  output rwa_pkg::rwa_stat_t         st,
  input  logic [rwa_pkg::CMD_W-1:0]  in_cmd,
  input  logic [rwa_pkg::DATA_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rwa_pkg::DATA_W-1:0] out_mean_value,
  output logic                       out_not_empty,
  output logic [rwa_pkg::FILL_W-1:0] out_fill_count
);
  import rwa_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int STEP_W = $clog2(SUM_W);

  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] value_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] mean_r;
  logic              has_r;
  logic [FILL_W-1:0] fill_r;

  logic [DATA_W-1:0] old_sample;
  logic              full;
  logic              is_add;
  logic [SUM_W-1:0]  sum_nxt;
  logic [PTR_W-1:0]  ptr_nxt;
  logic [CNT_W:0]    shifted;
  logic              fits;
  logic [CNT_W:0]    diff;
  logic [CNT_W+FILL_W-1:0] fill_wide;

  rwa_ram #(
    .WIDTH(DATA_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.update && is_add),
    .waddr(ptr_r),
    .wdata(value_r),
    .re   (cmd.accept),
    .raddr(ptr_r),
    .rdata(old_sample)
  );

  assign is_add  = (cmd_r == CMD_ADD);
  assign full    = (cnt_r == CNT_W'(WINDOW));
  assign sum_nxt = sum_r + SUM_W'(value_r) - (full ? SUM_W'(old_sample) : '0);
  assign ptr_nxt = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign fits    = (shifted >= {1'b0, cnt_r});
  assign diff    = shifted - {1'b0, cnt_r};

  assign fill_wide = {FILL_W'(0), cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
    end
    if (cmd.div_start) begin
      rem_r  <= '0;
      quo_r  <= sum_r;
      step_r <= STEP_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      rem_r  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_r  <= {quo_r[SUM_W-2:0], fits};
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.out_load) begin
      mean_r <= (cnt_r == '0) ? '0 : quo_r[DATA_W-1:0];
      has_r  <= (cnt_r != '0);
      fill_r <= fill_wide[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (!is_add) begin
          sum_r <= '0;
          cnt_r <= '0;
          ptr_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          ptr_r <= ptr_nxt;
          if (!full) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.div_last = (step_r == '0);
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_mean_value = mean_r;
  assign out_not_empty  = has_r;
  assign out_fill_count = fill_r;

endmodule
